FILE: sv/ipd_pkg.sv
package ipd_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned WAKE_PAIRS    = 5;
  localparam int unsigned IDX_W         = 5;
  localparam int unsigned ADDR_W        = 5;

  localparam logic [2:0] REG_HDR_MARK   = 3'd0;
  localparam logic [2:0] REG_HDR_SPACE  = 3'd1;
  localparam logic [2:0] REG_ONE_MARK   = 3'd2;
  localparam logic [2:0] REG_ONE_SPACE  = 3'd3;
  localparam logic [2:0] REG_ZERO_MARK  = 3'd4;
  localparam logic [2:0] REG_ZERO_SPACE = 3'd5;

  localparam logic [15:0] RST_HDR_MARK   = 16'd3650;
  localparam logic [15:0] RST_HDR_SPACE  = 16'd1623;
  localparam logic [15:0] RST_ONE_MARK   = 16'd428;
  localparam logic [15:0] RST_ONE_SPACE  = 16'd1280;
  localparam logic [15:0] RST_ZERO_MARK  = 16'd428;
  localparam logic [15:0] RST_ZERO_SPACE = 16'd428;

  localparam logic [IDX_W-1:0] WAKE_SEGS = IDX_W'(2 * WAKE_PAIRS + 1);
  localparam logic [IDX_W-1:0] BYTE_SEGS = IDX_W'(2 * BITS_PER_BYTE);
  localparam logic [IDX_W-1:0] HDR_SEGS  = IDX_W'(2);
  localparam logic [IDX_W-1:0] TRL_POS   = HDR_SEGS + BYTE_SEGS;

  typedef struct packed {
    logic [15:0] hdr_mark;
    logic [15:0] hdr_space;
    logic [15:0] one_mark;
    logic [15:0] one_space;
    logic [15:0] zero_mark;
    logic [15:0] zero_space;
  } cfg_t;

endpackage

FILE: sv/ipd_cfg.sv
module ipd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ipd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ipd_pkg::cfg_t               cfg
);
  import ipd_pkg::*;

  logic       wr;
  logic [2:0] sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hdr_mark   <= RST_HDR_MARK;
      cfg.hdr_space  <= RST_HDR_SPACE;
      cfg.one_mark   <= RST_ONE_MARK;
      cfg.one_space  <= RST_ONE_SPACE;
      cfg.zero_mark  <= RST_ZERO_MARK;
      cfg.zero_space <= RST_ZERO_SPACE;
    end else if (wr) begin
      unique case (sel)
        REG_HDR_MARK:   cfg.hdr_mark   <= pwdata[15:0];
        REG_HDR_SPACE:  cfg.hdr_space  <= pwdata[15:0];
        REG_ONE_MARK:   cfg.one_mark   <= pwdata[15:0];
        REG_ONE_SPACE:  cfg.one_space  <= pwdata[15:0];
        REG_ZERO_MARK:  cfg.zero_mark  <= pwdata[15:0];
        REG_ZERO_SPACE: cfg.zero_space <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_HDR_MARK:   prdata = {16'd0, cfg.hdr_mark};
      REG_HDR_SPACE:  prdata = {16'd0, cfg.hdr_space};
      REG_ONE_MARK:   prdata = {16'd0, cfg.one_mark};
      REG_ONE_SPACE:  prdata = {16'd0, cfg.one_space};
      REG_ZERO_MARK:  prdata = {16'd0, cfg.zero_mark};
      REG_ZERO_SPACE: prdata = {16'd0, cfg.zero_space};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

FILE: sv/ipd_encoder.sv
module ipd_encoder (
  input  logic           clk,
  input  logic           rst,
  input  ipd_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           func,
  input  logic [7:0]     data_byte,
  input  logic           frame_start,
  input  logic           frame_end,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           level,
  output logic [15:0]    duration_us,
  output logic           last
);
  import ipd_pkg::*;

  logic             hold_valid;
  logic             hold_func;
  logic [7:0]       hold_data;
  logic             hold_start;
  logic             hold_end;
  logic [IDX_W-1:0] idx;

  logic [IDX_W-1:0] seg_cnt;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] bit_pos;
  logic [2:0]       bit_sel;
  logic             seg_level;
  logic [15:0]      seg_dur;
  logic             seg_last;
  logic             load;
  logic             in_accept;

  always_comb begin
    seg_cnt = BYTE_SEGS + {3'd0, hold_start, 1'b0} + {3'd0, hold_end, 1'b0};
    if (hold_func) begin
      seg_cnt = WAKE_SEGS;
    end
  end

  assign pos     = hold_start ? idx : idx + HDR_SEGS;
  assign bit_pos = pos - HDR_SEGS;
  assign bit_sel = bit_pos[3:1];

  always_comb begin
    seg_level = ~pos[0];
    seg_dur   = cfg.zero_mark;
    if (hold_func) begin
      seg_level = idx[0];
      seg_dur   = cfg.zero_mark;
    end else if (pos < HDR_SEGS) begin
      seg_dur = pos[0] ? cfg.hdr_space : cfg.hdr_mark;
    end else if (pos < TRL_POS) begin
      if (hold_data[bit_sel]) begin
        seg_dur = pos[0] ? cfg.one_space : cfg.one_mark;
      end else begin
        seg_dur = pos[0] ? cfg.zero_space : cfg.zero_mark;
      end
    end else begin
      seg_dur = pos[0] ? cfg.zero_space : cfg.one_mark;
    end
  end

  assign seg_last  = (idx == seg_cnt - IDX_W'(1));
  assign load      = hold_valid && (!out_valid || !out_stall);
  assign in_stall  = hold_valid && !(load && seg_last);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx        <= '0;
    end else if (in_accept) begin
      hold_valid <= 1'b1;
      idx        <= '0;
    end else if (load) begin
      hold_valid <= !seg_last;
      idx        <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_func  <= func;
      hold_data  <= data_byte;
      hold_start <= frame_start;
      hold_end   <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      level       <= seg_level;
      duration_us <= seg_dur;
      last        <= seg_last;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> idx < seg_cnt)
    else $error("segment index past end of item");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> hold_valid && idx == '0)
    else $error("accepted word did not start at first segment");

  a_continue: assert property (@(posedge clk) disable iff (rst)
    load && !seg_last && !in_accept |=> hold_valid)
    else $error("item dropped before its last segment");

  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !load |=> $stable(idx))
    else $error("segment index moved while output stalled");

endmodule

FILE: sv/ir_pulse_distance_frame_encoder_core.sv
// An accepted word is first held in the hold register; its first segment then loads into the output register.
// Throughput: one segment per cycle while the output is not stalled; a word has 11 (wake), 16, 18 or 20 segments,
// set by the segment counter that walks the held word through the output register.
// The next word is accepted in the cycle its final segment moves to the output.
// Reset (rst, synchronous, active high) empties both stages and restores register defaults.
module ir_pulse_distance_frame_encoder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ipd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        func,
  input  logic [7:0]                  data_byte,
  input  logic                        frame_start,
  input  logic                        frame_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        level,
  output logic [15:0]                 duration_us,
  output logic                        last
);
  import ipd_pkg::*;

  cfg_t cfg;

  ipd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ipd_encoder u_enc (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .frame_end   (frame_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .level       (level),
    .duration_us (duration_us),
    .last        (last)
  );

endmodule
